/* hdl/psl_pkg.sv */
`default_nettype none

package psl_pkg;

   localparam int CAPACITY   = 128;
   localparam int ELEM_WIDTH = 32;

   // Wide enough to hold a length of CAPACITY itself.
   localparam int IDX_W = $clog2(CAPACITY + 1);
   // Common width for comparing an 8-bit position against an index.
   localparam int CMP_W = ((IDX_W > 8) ? IDX_W : 8) + 1;

   localparam logic [2:0] OP_GET    = 3'd0;
   localparam logic [2:0] OP_LOCATE = 3'd1;
   localparam logic [2:0] OP_INSERT = 3'd2;
   localparam logic [2:0] OP_DELETE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic [2:0]            op;
      logic [7:0]            pos;
      logic [ELEM_WIDTH-1:0] val;
      logic [IDX_W-1:0]      len;
      logic                  shift_up;
      logic                  shift_down;
   } psl_cmd_type;

   // Search result handed from cell to cell towards the head of the list.
   typedef struct packed {
      logic                  hit;
      logic [ELEM_WIDTH-1:0] data;
      logic [IDX_W-1:0]      idx;
   } psl_carry_type;

endpackage

`default_nettype wire

/* hdl/psl_cell.sv */
`default_nettype none

module psl_cell (
   input  wire logic                          clock,
   input  wire logic [psl_pkg::IDX_W-1:0]     cell_index,
   input  wire psl_pkg::psl_cmd_type          cmd,
   input  wire logic [psl_pkg::ELEM_WIDTH-1:0] left_entry,
   input  wire logic [psl_pkg::ELEM_WIDTH-1:0] right_entry,
   input  wire psl_pkg::psl_carry_type        carry_up,
   output      logic [psl_pkg::ELEM_WIDTH-1:0] entry,
   output      psl_pkg::psl_carry_type        carry_down
);

   logic [psl_pkg::ELEM_WIDTH-1:0] entry_ff, entry_in;
   psl_pkg::psl_carry_type         carry_ff, carry_in;
   logic [psl_pkg::IDX_W-1:0]      pos_here;
   logic [psl_pkg::CMP_W-1:0]      pos_wide, here_wide;
   logic                           at_pos, past_pos, match;

   // This cell holds list position cell_index + 1.
   assign pos_here  = cell_index + psl_pkg::IDX_W'(1);
   assign pos_wide  = psl_pkg::CMP_W'(cmd.pos);
   assign here_wide = psl_pkg::CMP_W'(pos_here);
   assign at_pos    = (here_wide == pos_wide);
   assign past_pos  = (here_wide > pos_wide);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_up) begin
         if (at_pos) begin
            entry_in = cmd.val;
         end else if (past_pos) begin
            entry_in = left_entry;
         end
      end else if (cmd.shift_down) begin
         if (at_pos || past_pos) begin
            entry_in = right_entry;
         end
      end
   end

   always_comb begin
      if (cmd.op == psl_pkg::OP_LOCATE) begin
         match = (cell_index < cmd.len) && (entry_ff == cmd.val);
      end else begin
         match = at_pos;
      end
      carry_in = carry_up;
      if (match) begin
         carry_in.hit  = 1'b1;
         carry_in.data = entry_ff;
         carry_in.idx  = pos_here;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign entry      = entry_ff;
   assign carry_down = carry_ff;

endmodule

`default_nettype wire

/* hdl/positional_sequential_list.sv */
`default_nettype none

// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  func, position, value
// rsp_       out        rsp_valid/rsp_stall  data, found_position, count, status
//
// Insert, clear, unused codes and every rejected request go from acceptance through the
// decision state to the response register. Other gets, locates and deletes first sweep
// while the search result travels through the chain of cells, one cell per cycle. One
// transaction is in flight at a time; the response register holds a finished result while
// the next request is accepted. Reset is synchronous and active high and empties the list;
// entry contents are not cleared. A stalled response holds the block in its final state.

module positional_sequential_list (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_position,
   input  wire logic [31:0] req_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_data,
   output      logic [7:0]  rsp_found_position,
   output      logic [7:0]  rsp_count,
   output      logic [1:0]  rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SWEEP  = 4'b0100,
      S_FINISH = 4'b1000
   } psl_state_type;

   psl_state_type state_ff, state_in;

   // Latched request.
   logic [2:0]                     op_ff, op_in;
   logic [7:0]                     pos_ff, pos_in;
   logic [psl_pkg::ELEM_WIDTH-1:0] val_ff, val_in;
   logic [1:0]                     status_ff, status_in;

   logic [psl_pkg::IDX_W-1:0]      len_ff, len_in;
   logic [psl_pkg::IDX_W-1:0]      sweep_cnt_ff, sweep_cnt_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [7:0]  rsp_found_ff, rsp_found_in;
   logic [7:0]  rsp_count_ff, rsp_count_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic                      req_accept, rsp_free, commit;
   logic [psl_pkg::CMP_W-1:0] pos_wide, len_wide;
   logic                      pos_in_list, pos_for_insert, list_full;

   psl_pkg::psl_cmd_type           cmd;
   logic [psl_pkg::ELEM_WIDTH-1:0] entry_w [psl_pkg::CAPACITY];
   psl_pkg::psl_carry_type         carry_w [psl_pkg::CAPACITY+1];

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign commit     = (state_ff == S_FINISH) && rsp_free;

   // Position checks, done on the latched request in the decision cycle.
   assign pos_wide       = psl_pkg::CMP_W'(pos_ff);
   assign len_wide       = psl_pkg::CMP_W'(len_ff);
   assign pos_in_list    = (pos_ff != 8'd0) && (pos_wide <= len_wide);
   assign pos_for_insert = (pos_ff != 8'd0) && (pos_wide <= len_wide + psl_pkg::CMP_W'(1));
   assign list_full      = (len_ff == psl_pkg::IDX_W'(psl_pkg::CAPACITY));

   // Every cell sees the same command; the shifts happen only on commit.
   always_comb begin
      cmd.op         = op_ff;
      cmd.pos        = pos_ff;
      cmd.val        = val_ff;
      cmd.len        = len_ff;
      cmd.shift_up   = commit && (op_ff == psl_pkg::OP_INSERT)
                       && (status_ff == psl_pkg::STATUS_OK);
      cmd.shift_down = commit && (op_ff == psl_pkg::OP_DELETE)
                       && (status_ff == psl_pkg::STATUS_OK);
   end

   // The tail of the chain feeds an empty search result.
   assign carry_w[psl_pkg::CAPACITY] = '0;

   for (genvar k = 0; k < psl_pkg::CAPACITY; k++) begin : g_cell
      logic [psl_pkg::ELEM_WIDTH-1:0] left_w, right_w;
      if (k == 0) begin : g_head
         assign left_w = entry_w[k];
      end else begin : g_left
         assign left_w = entry_w[k-1];
      end
      if (k == psl_pkg::CAPACITY - 1) begin : g_tail
         assign right_w = entry_w[k];
      end else begin : g_right
         assign right_w = entry_w[k+1];
      end
      psl_cell u_cell (
         .clock       (clock),
         .cell_index  (psl_pkg::IDX_W'(k)),
         .cmd         (cmd),
         .left_entry  (left_w),
         .right_entry (right_w),
         .carry_up    (carry_w[k+1]),
         .entry       (entry_w[k]),
         .carry_down  (carry_w[k])
      );
   end

   // Control sequence: latch, decide, let the search result reach the head
   // of the chain when one is needed, then commit and respond.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      sweep_cnt_in = sweep_cnt_ff;
      len_in       = len_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_func;
               pos_in   = req_position;
               val_in   = req_value[psl_pkg::ELEM_WIDTH-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in    = psl_pkg::STATUS_OK;
            sweep_cnt_in = psl_pkg::IDX_W'(psl_pkg::CAPACITY - 1);
            state_in     = S_FINISH;
            unique case (op_ff) inside
               psl_pkg::OP_GET, psl_pkg::OP_DELETE: begin
                  if (pos_in_list) begin
                     state_in = S_SWEEP;
                  end else begin
                     status_in = psl_pkg::STATUS_RANGE;
                  end
               end
               psl_pkg::OP_LOCATE: begin
                  state_in = S_SWEEP;
               end
               psl_pkg::OP_INSERT: begin
                  if (!pos_for_insert) begin
                     status_in = psl_pkg::STATUS_RANGE;
                  end else if (list_full) begin
                     status_in = psl_pkg::STATUS_FULL;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff - psl_pkg::IDX_W'(1);
            if (sweep_cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
               if (status_ff == psl_pkg::STATUS_OK) begin
                  if (op_ff == psl_pkg::OP_INSERT) begin
                     len_in = len_ff + psl_pkg::IDX_W'(1);
                  end else if (op_ff == psl_pkg::OP_DELETE) begin
                     len_in = len_ff - psl_pkg::IDX_W'(1);
                  end else if (op_ff == psl_pkg::OP_CLEAR) begin
                     len_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The response register is loaded on commit and emptied when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_count_in  = 8'(len_in);
         rsp_data_in   = '0;
         rsp_found_in  = '0;
         if (status_ff == psl_pkg::STATUS_OK
             && (op_ff == psl_pkg::OP_GET || op_ff == psl_pkg::OP_DELETE)) begin
            rsp_data_in = 32'(carry_w[0].data);
         end
         if (op_ff == psl_pkg::OP_LOCATE && carry_w[0].hit) begin
            rsp_found_in = 8'(carry_w[0].idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      sweep_cnt_ff  <= sweep_cnt_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   // An accepted request always moves on to the decision cycle.
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_EXEC)
      else $error("accepted request did not reach decision cycle");

   // A full-list rejection only happens when the length is at capacity.
   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      (commit && status_ff == psl_pkg::STATUS_FULL)
      |-> len_ff == psl_pkg::IDX_W'(psl_pkg::CAPACITY))
      else $error("full status with spare room");

   // A successful delete shortens the list by exactly one.
   a_delete_len: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == psl_pkg::OP_DELETE && status_ff == psl_pkg::STATUS_OK)
      |=> len_ff == $past(len_ff) - psl_pkg::IDX_W'(1))
      else $error("delete did not shorten the list");

   // A located position always lies inside the list.
   a_locate_in_list: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == psl_pkg::OP_LOCATE && carry_w[0].hit)
      |-> (carry_w[0].idx != '0 && carry_w[0].idx <= len_ff))
      else $error("located position outside the list");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_positional_sequential_list.sv */
`default_nettype none

module tb_positional_sequential_list;

   timeunit 1ns;
   timeprecision 1ps;

   // The longest operations (get, locate, delete) walk the whole chain of cells.
   localparam int LONG_LATENCY   = psl_pkg::CAPACITY + 2;
   // Cycles without any accepted transaction on either channel before giving up.
   localparam int WATCHDOG_LIMIT = 20 * LONG_LATENCY + 1000;
   // Quiet cycles after the last response, to catch any stray response.
   localparam int TAIL_CYCLES    = 2 * LONG_LATENCY;
   localparam int TOTAL_ITEMS    = 825;
   // Accepted-request window in which neither side idles or stalls.
   localparam int CALM_FIRST     = 300;
   localparam int CALM_LAST      = 450;
   localparam int IDLE_PERCENT   = 33;

   // One queued request. A hold entry carries no transaction: the driver waits
   // on it until every outstanding response has been returned.
   typedef struct {
      bit          hold;
      logic [2:0]  func;
      logic [7:0]  position;
      logic [31:0] value;
   } list_request_type;

   typedef struct packed {
      logic [31:0] data;
      logic [7:0]  found_position;
      logic [7:0]  count;
      logic [1:0]  status;
   } list_response_type;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func     = '0;
   logic [7:0]  req_position = '0;
   logic [31:0] req_value    = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [31:0] rsp_data;
   logic [7:0]  rsp_found_position;
   logic [7:0]  rsp_count;
   logic [1:0]  rsp_status;

   list_request_type  request_backlog[$];
   list_response_type expected_responses[$];

   // The testbench's own copy of the list, advanced once per accepted request.
   logic [psl_pkg::ELEM_WIDTH-1:0] shadow_entries [psl_pkg::CAPACITY];
   int                             shadow_length = 0;

   // Length as the stimulus generator sees it, used only to aim positions.
   int   planned_length = 0;
   logic [31:0] value_pool [12];

   int   requests_accepted = 0;
   int   quiet_cycles      = 0;
   bit   failed            = 1'b0;
   logic calm;

   assign calm = (requests_accepted >= CALM_FIRST) && (requests_accepted < CALM_LAST);

   always #6 clock = ~clock;

   positional_sequential_list dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .rsp_found_position (rsp_found_position),
      .rsp_count          (rsp_count),
      .rsp_status         (rsp_status)
   );

   // Applies one accepted request to the shadow list and records the response
   // that the block must give for it. Every request yields exactly one response.
   task automatic predict_list_op(input logic [2:0] func, input logic [7:0] position,
                                  input logic [31:0] value);
      list_response_type resp;
      int                pos;
      int                k;
      bit                hit;
      resp = '0;
      pos  = int'(position);
      hit  = 1'b0;
      case (func)
         psl_pkg::OP_GET: begin
            if (pos < 1 || pos > shadow_length)
               resp.status = psl_pkg::STATUS_RANGE;
            else
               resp.data = 32'(shadow_entries[pos-1]);
         end
         psl_pkg::OP_LOCATE: begin
            // Only the first match counts; an empty list never matches.
            for (k = 0; k < shadow_length; k++) begin
               if (!hit && shadow_entries[k] == value[psl_pkg::ELEM_WIDTH-1:0]) begin
                  hit = 1'b1;
                  resp.found_position = 8'(k + 1);
               end
            end
         end
         psl_pkg::OP_INSERT: begin
            // The position check takes precedence over the full-list check.
            if (pos < 1 || pos > shadow_length + 1) begin
               resp.status = psl_pkg::STATUS_RANGE;
            end else if (shadow_length >= psl_pkg::CAPACITY) begin
               resp.status = psl_pkg::STATUS_FULL;
            end else begin
               for (k = shadow_length; k >= pos; k--)
                  shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[pos-1] = value[psl_pkg::ELEM_WIDTH-1:0];
               shadow_length++;
            end
         end
         psl_pkg::OP_DELETE: begin
            if (pos < 1 || pos > shadow_length) begin
               resp.status = psl_pkg::STATUS_RANGE;
            end else begin
               resp.data = 32'(shadow_entries[pos-1]);
               for (k = pos; k < shadow_length; k++)
                  shadow_entries[k-1] = shadow_entries[k];
               shadow_length--;
            end
         end
         psl_pkg::OP_CLEAR: begin
            shadow_length = 0;
         end
         default: begin
            // The unused codes leave everything alone and report success.
         end
      endcase
      resp.count = 8'(shadow_length);
      expected_responses.push_back(resp);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $realtime, name, want, got);
         failed = 1'b1;
      end
   endtask

   // Queues one request and keeps the planned length in step, so that later
   // positions can be aimed inside or just outside the list.
   task automatic queue_request(input logic [2:0] func, input int position,
                                input logic [31:0] value);
      list_request_type item;
      item.hold     = 1'b0;
      item.func     = func;
      item.position = 8'(position);
      item.value    = value;
      request_backlog.push_back(item);
      case (func)
         psl_pkg::OP_INSERT:
            if (position >= 1 && position <= planned_length + 1 &&
                planned_length < psl_pkg::CAPACITY)
               planned_length++;
         psl_pkg::OP_DELETE:
            if (position >= 1 && position <= planned_length)
               planned_length--;
         psl_pkg::OP_CLEAR:
            planned_length = 0;
         default: ;
      endcase
   endtask

   task automatic queue_hold();
      list_request_type item;
      item          = '{default: '0};
      item.hold     = 1'b1;
      request_backlog.push_back(item);
   endtask

   // Pool values recur often enough that locate finds real matches and
   // duplicates appear in the list.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 99) < 40)
         return value_pool[$urandom_range(0, 11)];
      return $urandom;
   endfunction

   // Driver: offers the next queued transaction whenever the channel is free
   // and it does not choose to idle. A transaction stays on the port, unchanged,
   // until it is accepted, and each port gets one assignment per edge.
   always @(posedge clock) begin : request_driver
      list_request_type next_item;
      logic             offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            predict_list_op(req_func, req_position, req_value);
            requests_accepted++;
            offer = 1'b0;
         end
         if (!offer && request_backlog.size() != 0 &&
             (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            if (request_backlog[0].hold) begin
               // Pause the sender until the block has returned everything.
               if (expected_responses.size() == 0)
                  void'(request_backlog.pop_front());
            end else begin
               next_item = request_backlog.pop_front();
               req_func     <= next_item.func;
               req_position <= next_item.position;
               req_value    <= next_item.value;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // Monitor: stalls the response channel at random, checks every accepted
   // response against the oldest prediction and keeps the watchdog count.
   always @(posedge clock) begin : response_monitor
      list_response_type want;
      if (reset) begin
         rsp_stall    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual data 0x%0h count %0d",
                        $realtime, rsp_data, rsp_count);
               failed = 1'b1;
            end else begin
               want = expected_responses.pop_front();
               compare_field("data",           want.data,                rsp_data);
               compare_field("found_position", 32'(want.found_position),
                             32'(rsp_found_position));
               compare_field("count",          32'(want.count),          32'(rsp_count));
               compare_field("status",         32'(want.status),         32'(rsp_status));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Stimulus and end of test. The whole backlog is built at time zero; the
   // driver then feeds it to the block once reset has been released.
   initial begin : run_control
      int  pick;
      int  k;
      int  tail;
      bit  first_fill_done;
      bit  second_fill_done;

      first_fill_done  = 1'b0;
      second_fill_done = 1'b0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      for (k = 2; k < 12; k++)
         value_pool[k] = $urandom;

      // Directed transactions. First, everything that an empty list must reject or fail to find.
      queue_request(psl_pkg::OP_GET,    1, 32'h0);
      queue_request(psl_pkg::OP_DELETE, 1, 32'h0);
      queue_request(psl_pkg::OP_LOCATE, 0, 32'h0);
      queue_request(psl_pkg::OP_INSERT, 0, 32'h1111_1111);
      queue_request(psl_pkg::OP_INSERT, 2, 32'h2222_2222);
      // Build a short list by inserting at the end, the head and the middle.
      queue_request(psl_pkg::OP_INSERT, 1, 32'h0000_0000);
      queue_request(psl_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
      queue_request(psl_pkg::OP_INSERT, 1, 32'hA5A5_A5A5);
      queue_request(psl_pkg::OP_INSERT, 2, 32'h5A5A_5A5A);
      // Reads at both ends and just outside the list, including position 255.
      queue_request(psl_pkg::OP_GET, 1,   32'h0);
      queue_request(psl_pkg::OP_GET, 4,   32'h0);
      queue_request(psl_pkg::OP_GET, 5,   32'h0);
      queue_request(psl_pkg::OP_GET, 0,   32'h0);
      queue_request(psl_pkg::OP_GET, 255, 32'h0);
      // Locate a present value, an absent one, and the first of two duplicates.
      queue_request(psl_pkg::OP_LOCATE, 0, 32'hFFFF_FFFF);
      queue_request(psl_pkg::OP_LOCATE, 0, 32'h1234_5678);
      queue_request(psl_pkg::OP_INSERT, 1, 32'hFFFF_FFFF);
      queue_request(psl_pkg::OP_LOCATE, 0, 32'hFFFF_FFFF);
      // Deletes that must be refused, then one in the middle and one at the tail.
      queue_request(psl_pkg::OP_DELETE, 255, 32'h0);
      queue_request(psl_pkg::OP_DELETE, 0,   32'h0);
      queue_request(psl_pkg::OP_DELETE, 3,   32'h0);
      queue_request(psl_pkg::OP_DELETE, planned_length, 32'h0);
      // The unused codes must do nothing at all.
      for (k = 5; k < 8; k++)
         queue_request(3'(k), $urandom_range(0, 255), $urandom);
      queue_request(psl_pkg::OP_CLEAR, 0, 32'h0);
      queue_request(psl_pkg::OP_GET,   1, 32'h0);
      queue_hold();

      // Random part: mostly well-aimed operations on a growing list, with some
      // noise, occasional drain pauses and two runs that fill the list.
      while (request_backlog.size() < TOTAL_ITEMS) begin
         if ((!first_fill_done && request_backlog.size() > 250) ||
             (!second_fill_done && request_backlog.size() > 600)) begin
            // Fill to capacity: random positions the first time, appends later.
            while (planned_length < psl_pkg::CAPACITY) begin
               if (!first_fill_done)
                  queue_request(psl_pkg::OP_INSERT, $urandom_range(1, planned_length + 1),
                                pick_value());
               else
                  queue_request(psl_pkg::OP_INSERT, planned_length + 1, pick_value());
            end
            // On a full list a valid position reports full; a bad one reports range.
            queue_request(psl_pkg::OP_INSERT, planned_length + 1, $urandom);
            queue_request(psl_pkg::OP_INSERT, $urandom_range(1, planned_length), $urandom);
            queue_request(psl_pkg::OP_INSERT, 255, $urandom);
            queue_request(psl_pkg::OP_INSERT, 0, $urandom);
            queue_request(psl_pkg::OP_GET, psl_pkg::CAPACITY, 32'h0);
            queue_request(psl_pkg::OP_GET, 1, 32'h0);
            queue_request(psl_pkg::OP_LOCATE, 0, pick_value());
            queue_request(psl_pkg::OP_DELETE, psl_pkg::CAPACITY, 32'h0);
            queue_request(psl_pkg::OP_DELETE, $urandom_range(1, planned_length), 32'h0);
            if (!first_fill_done)
               first_fill_done = 1'b1;
            else
               second_fill_done = 1'b1;
         end
         for (k = 0; k < 30; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && planned_length < psl_pkg::CAPACITY)
               queue_request(psl_pkg::OP_INSERT, $urandom_range(1, planned_length + 1),
                             pick_value());
            else if (pick < 50 && planned_length > 0)
               queue_request(psl_pkg::OP_GET, $urandom_range(1, planned_length), $urandom);
            else if (pick < 62)
               queue_request(psl_pkg::OP_LOCATE, $urandom_range(0, 255), pick_value());
            else if (pick < 80 && planned_length > 0)
               queue_request(psl_pkg::OP_DELETE, $urandom_range(1, planned_length), $urandom);
            else if (pick < 83)
               queue_request(psl_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom);
            else if (pick < 88)
               queue_request(3'($urandom_range(5, 7)), $urandom_range(0, 255), $urandom);
            else
               queue_request(3'($urandom_range(0, 4)), $urandom_range(0, 255), $urandom);
         end
         if ($urandom_range(0, 4) == 0)
            queue_hold();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while ((request_backlog.size() != 0 || req_valid || expected_responses.size() != 0) &&
             quiet_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      tail = 0;
      while (tail < TAIL_CYCLES && quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         tail++;
      end

      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding",
                  $realtime, expected_responses.size());
         $display("** positional_sequential_list: FAILED **");
      end else if (!failed && expected_responses.size() == 0) begin
         $display("** positional_sequential_list: PASSED **");
      end else begin
         if (expected_responses.size() != 0)
            $display("%0t: %0d expected responses never arrived",
                     $realtime, expected_responses.size());
         $display("** positional_sequential_list: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
